// ===== src/lru_page_replacement_unit_macros.svh =====
// ----------------------------------------------------------------------------
// LRU page replacement unit - assertion macros
// Shared concurrent assertion forms used by the RTL of the replacement unit.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define LRUPR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LRUPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Types, constants and codes shared by the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // Default sizing
   localparam int SLOTS_DEF     = 16;
   localparam int PAGE_BITS_DEF = 16;
   localparam int AGE_BITS_DEF  = 16;

   // Fixed field widths of the item ports
   localparam int PAGE_FIELD_W  = 16;
   localparam int SLOT_INDEX_W  = 4;
   localparam int FAULT_W       = 32;
   localparam int ACTIVE_W      = 5;

   // Register file
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam logic REG_ACTIVE_SLOTS = 1'b0;
   localparam logic [ACTIVE_W-1:0] ACTIVE_SLOTS_RST = 5'd16;

   // Action codes
   localparam logic ACTION_ACCESS = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [PAGE_FIELD_W-1:0] page_number;
   } req_item_type;

   typedef struct packed {
      logic                    hit;
      logic [SLOT_INDEX_W-1:0] slot_index;
      logic                    evicted;
      logic [PAGE_FIELD_W-1:0] evicted_page;
      logic [FAULT_W-1:0]      fault_count;
   } rsp_item_type;

   // Flags travelling down the search chain
   typedef struct packed {
      logic hit_found;
      logic empty_found;
      logic best_set;
   } scan_flags_type;

   // Update command broadcast to every cell
   typedef struct packed {
      logic fire;
      logic clear;
      logic write;
   } upd_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } ctl_state_type;

endpackage

// ===== src/lru_page_replacement_unit.sv =====
// Items are taken only in the idle state, so a new item waits until the last one
// is through its update. The search walks the row of slot cells one cell per
// cycle through registered hand-offs, then the update state writes the result
// once the output is free. A held result does not block the next item until that item's update cycle.
// Reset (synchronous): all slots empty, ages and fault count zero,
// active_slots = 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// Fully associative resident set with per-slot age counters, LRU replacement
// and a saturating count of evicting faults.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_unit_macros.svh"

module lru_page_replacement_unit #(
   parameter int SLOTS     = lrupr_pkg::SLOTS_DEF,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
   parameter int AGE_BITS  = lrupr_pkg::AGE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request items
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lrupr_pkg::req_item_type              req_item,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lrupr_pkg::rsp_item_type              rsp_item,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lrupr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lrupr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lrupr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import lrupr_pkg::*;

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NCNT_W = $clog2(SLOTS + 1);

   // ---------------- register port ----------------
   logic [ACTIVE_W-1:0] active_slots_ff, active_slots_in;
   logic                csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      active_slots_in = active_slots_ff;
      if (csr_wr && csr_paddr[2] == REG_ACTIVE_SLOTS) begin
         active_slots_in = csr_pwdata[ACTIVE_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ACTIVE_SLOTS) ?
                       CSR_DATA_W'(active_slots_ff) : '0;

   // Effective set size, clamped to 1..SLOTS
   logic [NCNT_W-1:0] used_slots;
   always_comb begin
      if (active_slots_ff == '0) begin
         used_slots = NCNT_W'(1);
      end else if (32'(active_slots_ff) > SLOTS) begin
         used_slots = NCNT_W'(SLOTS);
      end else begin
         used_slots = NCNT_W'(active_slots_ff);
      end
   end

   // ---------------- control ----------------
   ctl_state_type        state_ff, state_in;
   logic [IDX_W-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [PAGE_BITS-1:0] probe_page_ff, probe_page_in;
   logic                 probe_clear_ff, probe_clear_in;
   logic                 req_accept;
   logic                 out_free;
   logic                 upd_fire;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_cnt_ff == IDX_W'(SLOTS - 1)) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      upd_fire  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_SCAN:   req_stall = 1'b1;
         ST_UPDATE: upd_fire  = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   // Scan counter and probe capture
   always_comb begin
      scan_cnt_in    = scan_cnt_ff;
      probe_page_in  = probe_page_ff;
      probe_clear_in = probe_clear_ff;
      if (req_accept) begin
         scan_cnt_in    = '0;
         probe_page_in  = PAGE_BITS'(req_item.page_number);
         probe_clear_in = (req_item.action == ACTION_CLEAR);
      end else if (state_ff == ST_SCAN) begin
         scan_cnt_in = scan_cnt_ff + IDX_W'(1);
      end
   end

   // ---------------- cell row ----------------
   scan_flags_type       scan_flags [SLOTS+1];
   logic [IDX_W-1:0]     hit_idx    [SLOTS+1];
   logic [IDX_W-1:0]     sel_idx    [SLOTS+1];
   logic [AGE_BITS-1:0]  best_age   [SLOTS+1];
   logic [PAGE_BITS-1:0] best_page  [SLOTS+1];
   logic [SLOTS-1:0]     cell_active;
   upd_cmd_type          upd_cmd;
   logic [IDX_W-1:0]     keep_idx;

   assign scan_flags[0] = '0;
   assign hit_idx[0]    = '0;
   assign sel_idx[0]    = '0;
   assign best_age[0]   = '0;
   assign best_page[0]  = '0;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      assign cell_active[k] = (32'(used_slots) > k);

      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .AGE_BITS  (AGE_BITS),
         .IDX_W     (IDX_W),
         .CELL_IDX  (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_active  (cell_active[k]),
         .probe_page   (probe_page_ff),
         .scan_flags_i (scan_flags[k]),
         .hit_idx_i    (hit_idx[k]),
         .sel_idx_i    (sel_idx[k]),
         .best_age_i   (best_age[k]),
         .best_page_i  (best_page[k]),
         .scan_flags_o (scan_flags[k+1]),
         .hit_idx_o    (hit_idx[k+1]),
         .sel_idx_o    (sel_idx[k+1]),
         .best_age_o   (best_age[k+1]),
         .best_page_o  (best_page[k+1]),
         .upd_cmd      (upd_cmd),
         .keep_idx     (keep_idx)
      );
   end

   // ---------------- decision ----------------
   scan_flags_type final_flags;
   logic           is_hit;
   logic           is_evict;

   assign final_flags = scan_flags[SLOTS];
   assign is_hit      = final_flags.hit_found;
   assign is_evict    = !final_flags.hit_found && !final_flags.empty_found;
   assign keep_idx    = is_hit ? hit_idx[SLOTS] : sel_idx[SLOTS];

   assign upd_cmd = '{fire: upd_fire, clear: probe_clear_ff, write: !is_hit};

   // Fault count and result register
   logic [FAULT_W-1:0] fault_ff, fault_in;
   rsp_item_type       rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      fault_in = fault_ff;
      if (upd_fire) begin
         if (probe_clear_ff) begin
            fault_in = '0;
         end else if (is_evict && fault_ff != '1) begin
            fault_in = fault_ff + FAULT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (upd_fire) begin
         if (probe_clear_ff) begin
            rsp_in = '0;
         end else begin
            rsp_in.hit          = is_hit;
            rsp_in.slot_index   = SLOT_INDEX_W'(keep_idx);
            rsp_in.evicted      = is_evict;
            rsp_in.evicted_page = is_evict ? PAGE_FIELD_W'(best_page[SLOTS]) : '0;
            rsp_in.fault_count  = fault_in;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_slots_ff <= ACTIVE_SLOTS_RST;
         fault_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         scan_cnt_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         active_slots_ff <= active_slots_in;
         fault_ff        <= fault_in;
         rsp_valid_ff    <= rsp_valid_in;
         scan_cnt_ff     <= scan_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_page_ff  <= probe_page_in;
      probe_clear_ff <= probe_clear_in;
      rsp_ff         <= rsp_in;
   end

   // ---------------- assertions ----------------
   `LRUPR_ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_valid_ff && rsp_stall, !upd_fire, "held result overwritten")
   `LRUPR_ASSERT_NEXT(a_accept_scans, clock, reset, req_accept, state_ff == ST_SCAN, "accepted item did not start a scan")
   `LRUPR_ASSERT_IMPLY(a_evict_counts, clock, reset, rsp_valid_ff && rsp_ff.evicted, rsp_ff.fault_count != '0, "eviction with zero fault count")
   `LRUPR_ASSERT_IMPLY(a_hit_no_evict, clock, reset, rsp_valid_ff, !(rsp_ff.hit && rsp_ff.evicted), "hit and eviction together")

endmodule

// ===== src/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// lrupr_cell
// One resident-set slot: holds page, valid and age, takes one step of the
// registered search chain and applies the broadcast update.
// ----------------------------------------------------------------------------
module lrupr_cell #(
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
   parameter int AGE_BITS  = lrupr_pkg::AGE_BITS_DEF,
   parameter int IDX_W     = 4,
   parameter int CELL_IDX  = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cell_active,
   input  logic [PAGE_BITS-1:0]       probe_page,
   // search chain, from the previous cell
   input  lrupr_pkg::scan_flags_type  scan_flags_i,
   input  logic [IDX_W-1:0]           hit_idx_i,
   input  logic [IDX_W-1:0]           sel_idx_i,
   input  logic [AGE_BITS-1:0]        best_age_i,
   input  logic [PAGE_BITS-1:0]       best_page_i,
   // search chain, to the next cell
   output lrupr_pkg::scan_flags_type  scan_flags_o,
   output logic [IDX_W-1:0]           hit_idx_o,
   output logic [IDX_W-1:0]           sel_idx_o,
   output logic [AGE_BITS-1:0]        best_age_o,
   output logic [PAGE_BITS-1:0]       best_page_o,
   // update broadcast
   input  lrupr_pkg::upd_cmd_type     upd_cmd,
   input  logic [IDX_W-1:0]           keep_idx
);
   import lrupr_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 valid_ff, valid_in;
   logic [AGE_BITS-1:0]  age_ff, age_in;

   scan_flags_type       flags_ff, flags_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]     sel_idx_ff, sel_idx_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic [PAGE_BITS-1:0] best_page_ff, best_page_in;

   // Search step: first valid match, else first empty, else oldest (low index wins ties)
   always_comb begin
      flags_in     = scan_flags_i;
      hit_idx_in   = hit_idx_i;
      sel_idx_in   = sel_idx_i;
      best_age_in  = best_age_i;
      best_page_in = best_page_i;
      if (cell_active) begin
         if (!scan_flags_i.hit_found && valid_ff && page_ff == probe_page) begin
            flags_in.hit_found = 1'b1;
            hit_idx_in         = MY_IDX;
         end
         if (!scan_flags_i.empty_found) begin
            if (!valid_ff) begin
               flags_in.empty_found = 1'b1;
               sel_idx_in           = MY_IDX;
            end else if (!scan_flags_i.best_set || age_ff > best_age_i) begin
               flags_in.best_set = 1'b1;
               sel_idx_in        = MY_IDX;
               best_age_in       = age_ff;
               best_page_in      = page_ff;
            end
         end
      end
   end

   // Slot update: clear all, or reset kept age, fill on miss, age the rest
   always_comb begin
      page_in  = page_ff;
      valid_in = valid_ff;
      age_in   = age_ff;
      if (upd_cmd.fire) begin
         if (upd_cmd.clear) begin
            valid_in = 1'b0;
            age_in   = '0;
         end else if (cell_active) begin
            if (keep_idx == MY_IDX) begin
               age_in = '0;
               if (upd_cmd.write) begin
                  page_in  = probe_page;
                  valid_in = 1'b1;
               end
            end else if (valid_ff && age_ff != '1) begin
               age_in = age_ff + AGE_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         age_ff   <= '0;
         flags_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         age_ff   <= age_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      hit_idx_ff   <= hit_idx_in;
      sel_idx_ff   <= sel_idx_in;
      best_age_ff  <= best_age_in;
      best_page_ff <= best_page_in;
   end

   assign scan_flags_o = flags_ff;
   assign hit_idx_o    = hit_idx_ff;
   assign sel_idx_o    = sel_idx_ff;
   assign best_age_o   = best_age_ff;
   assign best_page_o  = best_page_ff;

endmodule
